// ===== hdl/gzcp_pkg.sv =====
// types and constants shared by the gzip/zlib container parser and its checker
package gzcp_pkg;

    localparam int OUT_TDATA_WIDTH = 136;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_SHORT   = 3'd1;
    localparam logic [2:0] ST_MAGIC   = 3'd2;
    localparam logic [2:0] ST_CHECK   = 3'd3;
    localparam logic [2:0] ST_METHOD  = 3'd4;
    localparam logic [2:0] ST_OVERRUN = 3'd5;

    localparam logic [7:0] GZ_ID1      = 8'h1F;
    localparam logic [7:0] GZ_ID2      = 8'h8B;
    localparam logic [7:0] CM_DEFLATE  = 8'h08;
    localparam int         FLG_FHCRC   = 1;
    localparam int         FLG_FEXTRA  = 2;
    localparam int         FLG_FNAME   = 3;
    localparam int         FLG_FCOMMENT = 4;
    localparam int         ZL_FDICT    = 5;
    localparam logic [3:0] ZL_MAX_CINFO = 4'd7;

    localparam logic [3:0] GZ_TRAILER = 4'd8;
    localparam logic [3:0] ZL_TRAILER = 4'd4;

    typedef enum logic [6:0] {
        PH_FIXED   = 7'b0000001,
        PH_XLO     = 7'b0000010,
        PH_XHI     = 7'b0000100,
        PH_SKIP    = 7'b0001000,
        PH_NAME    = 7'b0010000,
        PH_COMMENT = 7'b0100000,
        PH_BODY    = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [31:0] size_word;
        logic [31:0] check_word;
        logic [31:0] body_length;
        logic [31:0] header_length;
        logic [2:0]  status;
    } result_t;

endpackage

// ===== hdl/gzip_zlib_container_parser.sv =====
// gzip/zlib container framing parser: header walk, trailer capture, final report
//
//  channel   dir  handshake              payload
//  s_axis    in   tvalid/tready          tdata[7:0] data_byte, tlast last_byte
//  m_axis    out  tvalid/tready          tdata status..size_word, one per last byte
//  cfg       in   cfg_wr_en              cfg_wr_data container_format (0 gzip, 1 zlib)
//
//  one byte per cycle while no result waits unsent on m_axis: input register, one parse step, result register
//  a result is offered from the result register once the last byte leaves the input register with m_axis free
//  only a last byte waits in the input register while a result is still unsent
//  rst_n clears parse state and format to gzip, no clearing pass
module gzip_zlib_container_parser #(
    parameter int GZIP_MIN_LENGTH = 18,
    parameter int ZLIB_MIN_LENGTH = 6,
    parameter int COUNT_WIDTH     = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_wr_en,
    input  logic         cfg_wr_data,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  logic         s_axis_tlast,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // [2:0] status, [34:3] header_length, [66:35] body_length,
    // [98:67] check_word, [130:99] size_word, [135:131] zero
    output logic [gzcp_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

    localparam int CW = COUNT_WIDTH;
    localparam logic [CW-1:0] CNT_MAX  = {CW{1'b1}};
    localparam logic [CW-1:0] HE_RESET = CW'(10);
    localparam logic [CW-1:0] POS_ID1  = CW'(0);
    localparam logic [CW-1:0] POS_ID2  = CW'(1);
    localparam logic [CW-1:0] POS_CM   = CW'(2);
    localparam logic [CW-1:0] POS_FLG  = CW'(3);
    localparam logic [CW-1:0] POS_XFL_END = CW'(9);
    localparam logic [CW-1:0] GZ_MIN   = CW'(GZIP_MIN_LENGTH);
    localparam logic [CW-1:0] ZL_MIN   = CW'(ZLIB_MIN_LENGTH);
    localparam logic [CW-1:0] ZL_HDR_DICT  = CW'(6);
    localparam logic [CW-1:0] ZL_HDR_PLAIN = CW'(2);

    localparam logic [1:0] DONE_FIXED   = 2'd0;
    localparam logic [1:0] DONE_EXTRA   = 2'd1;
    localparam logic [1:0] DONE_NAME    = 2'd2;
    localparam logic [1:0] DONE_COMMENT = 2'd3;

    function automatic gzcp_pkg::phase_t next_field(input logic [1:0] done,
                                                    input logic [7:0] flg);
        gzcp_pkg::phase_t ph;
        ph = gzcp_pkg::PH_BODY;
        if (done < DONE_EXTRA && flg[gzcp_pkg::FLG_FEXTRA])
            ph = gzcp_pkg::PH_XLO;
        else if (done < DONE_NAME && flg[gzcp_pkg::FLG_FNAME])
            ph = gzcp_pkg::PH_NAME;
        else if (done < DONE_COMMENT && flg[gzcp_pkg::FLG_FCOMMENT])
            ph = gzcp_pkg::PH_COMMENT;
        return ph;
    endfunction

    // format register
    logic fmt_reg;

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_data_reg;
    logic       in_last_reg;

    // parse state
    logic [CW-1:0]    pos_reg, pos_next;
    logic [CW-1:0]    he_reg, he_next;
    gzcp_pkg::phase_t phase_reg, phase_next;
    logic [7:0]       flag_reg, flag_next;
    logic [7:0]       first_reg, first_next;
    logic [7:0]       xlo_reg, xlo_next;
    logic [2:0]       err_reg, err_next;
    logic [7:0]       tail_reg [8];
    logic [7:0]       tail_next [8];

    // result register
    logic              out_valid_reg, out_valid_next;
    gzcp_pkg::result_t out_reg, out_next;

    logic             s_fire, proc_fire;
    logic [CW-1:0]    n_pos;
    logic [7:0]       b;
    logic [15:0]      xlen;
    logic [CW-1:0]    he_base;
    logic [16:0]      he_addend;
    logic [CW:0]      he_sum;
    logic             forced_ovr;
    gzcp_pkg::phase_t nf;
    logic [11:0]      m31_s;
    logic [6:0]       m31_f1;
    logic [5:0]       m31_f2;
    logic [CW+1:0]    fin_sum;
    logic [CW+1:0]    body_diff;
    logic [CW-1:0]    min_len;
    logic [3:0]       trail;
    logic             overrun;
    logic [2:0]       status;
    logic [CW+31:0]   hl_wide, bl_wide;

    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign proc_fire     = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign in_valid_next = s_fire || (in_valid_reg && !proc_fire);

    assign b      = in_data_reg;
    assign xlen   = {b, xlo_reg};
    assign n_pos  = (pos_reg == CNT_MAX) ? pos_reg : pos_reg + CW'(1);

    // (256*first + b) mod 31 via 256 = 8 (mod 31) and 32 = 1 (mod 31)
    assign m31_s  = {1'b0, first_reg, 3'b000} + {4'b0000, b};
    assign m31_f1 = m31_s[11:5] + {2'b00, m31_s[4:0]};
    assign m31_f2 = {4'b0000, m31_f1[6:5]} + {1'b0, m31_f1[4:0]};

    always_comb
    begin
        phase_next = phase_reg;
        flag_next  = flag_reg;
        first_next = first_reg;
        xlo_next   = xlo_reg;
        err_next   = err_reg;
        he_base    = he_reg;
        he_addend  = 17'd0;
        forced_ovr = 1'b0;
        nf         = gzcp_pkg::PH_BODY;
        if (!fmt_reg)
        begin
            case (phase_reg)
                gzcp_pkg::PH_FIXED:
                begin
                    if (err_reg == gzcp_pkg::ST_OK)
                    begin
                        if ((pos_reg == POS_ID1 && b != gzcp_pkg::GZ_ID1) ||
                            (pos_reg == POS_ID2 && b != gzcp_pkg::GZ_ID2))
                            err_next = gzcp_pkg::ST_MAGIC;
                        else if (pos_reg == POS_CM && b != gzcp_pkg::CM_DEFLATE)
                            err_next = gzcp_pkg::ST_METHOD;
                    end
                    if (pos_reg == POS_FLG)
                        flag_next = b;
                    if (pos_reg >= POS_XFL_END)
                    begin
                        nf         = next_field(DONE_FIXED, flag_reg);
                        phase_next = nf;
                        if (nf == gzcp_pkg::PH_BODY && flag_reg[gzcp_pkg::FLG_FHCRC])
                            he_addend = 17'd2;
                    end
                end
                gzcp_pkg::PH_XLO:
                begin
                    xlo_next   = b;
                    phase_next = gzcp_pkg::PH_XHI;
                end
                gzcp_pkg::PH_XHI:
                begin
                    forced_ovr = 1'b1;
                    he_base    = n_pos;
                    he_addend  = {1'b0, xlen};
                    if (xlen == 16'd0 || n_pos == CNT_MAX)
                    begin
                        nf         = next_field(DONE_EXTRA, flag_reg);
                        phase_next = nf;
                        if (nf == gzcp_pkg::PH_BODY && flag_reg[gzcp_pkg::FLG_FHCRC])
                            he_addend = {1'b0, xlen} + 17'd2;
                    end
                    else
                    begin
                        phase_next = gzcp_pkg::PH_SKIP;
                    end
                end
                gzcp_pkg::PH_SKIP:
                begin
                    if (n_pos >= he_reg)
                    begin
                        nf         = next_field(DONE_EXTRA, flag_reg);
                        phase_next = nf;
                        if (nf == gzcp_pkg::PH_BODY && flag_reg[gzcp_pkg::FLG_FHCRC])
                            he_addend = 17'd2;
                    end
                end
                gzcp_pkg::PH_NAME:
                begin
                    forced_ovr = 1'b1;
                    if (b == 8'd0)
                    begin
                        he_base    = n_pos;
                        nf         = next_field(DONE_NAME, flag_reg);
                        phase_next = nf;
                        if (nf == gzcp_pkg::PH_BODY && flag_reg[gzcp_pkg::FLG_FHCRC])
                            he_addend = 17'd2;
                    end
                end
                gzcp_pkg::PH_COMMENT:
                begin
                    forced_ovr = 1'b1;
                    if (b == 8'd0)
                    begin
                        he_base    = n_pos;
                        nf         = next_field(DONE_COMMENT, flag_reg);
                        phase_next = nf;
                        if (nf == gzcp_pkg::PH_BODY && flag_reg[gzcp_pkg::FLG_FHCRC])
                            he_addend = 17'd2;
                    end
                end
                default:
                begin
                end
            endcase
        end
        else if (phase_reg == gzcp_pkg::PH_FIXED)
        begin
            if (pos_reg == POS_ID1)
            begin
                first_next = b;
            end
            else
            begin
                flag_next = b;
                if (err_reg == gzcp_pkg::ST_OK)
                begin
                    if (m31_f2 != 6'd0 && m31_f2 != 6'd31)
                        err_next = gzcp_pkg::ST_CHECK;
                    else if (first_reg[3:0] != gzcp_pkg::CM_DEFLATE[3:0] ||
                             first_reg[7:4] > gzcp_pkg::ZL_MAX_CINFO)
                        err_next = gzcp_pkg::ST_METHOD;
                end
                he_base    = b[gzcp_pkg::ZL_FDICT] ? ZL_HDR_DICT : ZL_HDR_PLAIN;
                phase_next = gzcp_pkg::PH_BODY;
            end
        end
    end

    assign he_sum  = {1'b0, he_base} + (CW+1)'(he_addend);
    assign he_next = he_sum[CW] ? CNT_MAX : he_sum[CW-1:0];
    assign pos_next = n_pos;

    always_comb
    begin
        for (int i = 0; i < 7; i++)
            tail_next[i] = tail_reg[i+1];
        tail_next[7] = b;
    end

    // final report
    assign trail     = fmt_reg ? gzcp_pkg::ZL_TRAILER : gzcp_pkg::GZ_TRAILER;
    assign min_len   = fmt_reg ? ZL_MIN : GZ_MIN;
    assign fin_sum   = {1'b0, he_sum} + (CW+2)'(trail);
    assign overrun   = forced_ovr || phase_next != gzcp_pkg::PH_BODY ||
                       fin_sum > {2'b00, n_pos};
    assign body_diff = {2'b00, n_pos} - fin_sum;

    always_comb
    begin
        if (n_pos < min_len)
            status = gzcp_pkg::ST_SHORT;
        else if (err_next != gzcp_pkg::ST_OK)
            status = err_next;
        else if (overrun)
            status = gzcp_pkg::ST_OVERRUN;
        else
            status = gzcp_pkg::ST_OK;
    end

    assign hl_wide = {32'd0, he_sum[CW-1:0]};
    assign bl_wide = {32'd0, body_diff[CW-1:0]};

    always_comb
    begin
        out_next.status        = status;
        out_next.header_length = (status == gzcp_pkg::ST_OK) ? hl_wide[31:0] : 32'd0;
        out_next.body_length   = (status == gzcp_pkg::ST_OK) ? bl_wide[31:0] : 32'd0;
        if (fmt_reg)
        begin
            out_next.check_word = {tail_next[4], tail_next[5], tail_next[6], tail_next[7]};
            out_next.size_word  = 32'd0;
        end
        else
        begin
            out_next.check_word = {tail_next[3], tail_next[2], tail_next[1], tail_next[0]};
            out_next.size_word  = {tail_next[7], tail_next[6], tail_next[5], tail_next[4]};
        end
    end

    always_comb
    begin
        if (proc_fire && in_last_reg)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg       <= 1'b0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
                fmt_reg <= cfg_wr_data;
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            in_data_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (proc_fire && in_last_reg)
            out_reg <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            he_reg    <= HE_RESET;
            phase_reg <= gzcp_pkg::PH_FIXED;
            flag_reg  <= 8'd0;
            first_reg <= 8'd0;
            xlo_reg   <= 8'd0;
            err_reg   <= gzcp_pkg::ST_OK;
            for (int i = 0; i < 8; i++)
                tail_reg[i] <= 8'd0;
        end
        else if (proc_fire)
        begin
            if (in_last_reg)
            begin
                // container done, back to the start state
                pos_reg   <= '0;
                he_reg    <= HE_RESET;
                phase_reg <= gzcp_pkg::PH_FIXED;
                flag_reg  <= 8'd0;
                first_reg <= 8'd0;
                xlo_reg   <= 8'd0;
                err_reg   <= gzcp_pkg::ST_OK;
                for (int i = 0; i < 8; i++)
                    tail_reg[i] <= 8'd0;
            end
            else
            begin
                pos_reg   <= pos_next;
                he_reg    <= he_next;
                phase_reg <= phase_next;
                flag_reg  <= flag_next;
                first_reg <= first_next;
                xlo_reg   <= xlo_next;
                err_reg   <= err_next;
                for (int i = 0; i < 8; i++)
                    tail_reg[i] <= tail_next[i];
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg};

endmodule

// ===== hdl/gzcp_checker.sv =====
// port-level checker for the gzip/zlib container parser, bound to the top level
module gzcp_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         s_axis_tlast,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [gzcp_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata
);

    // lengths only reported with an ok status
    a_len_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tdata[2:0] != gzcp_pkg::ST_OK) |->
        (m_axis_tdata[66:3] == 64'd0))
        else $error("lengths nonzero with error status");

    // a fresh result is offered only after a last-byte transfer, via the input and result registers
    a_result_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready && s_axis_tlast, 2))
        else $error("result without a preceding last transfer");

    // input only stalls behind an unsent result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (m_axis_tvalid && !m_axis_tready))
        else $error("input stalled without output backpressure");

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("result changed while stalled");

endmodule

bind gzip_zlib_container_parser gzcp_checker u_gzcp_checker (.*);
